@@ rtl/core/itaf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaf_pkg
// Shared types, constants and the digit-to-character lookup for the
// integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itaf_pkg;

  localparam int VALUE_W    = 64;
  localparam int MODE_W     = 3;
  localparam int CHAR_W     = 8;
  localparam int DEC_DIGITS = 19;
  localparam int BCD_W      = DEC_DIGITS * 4;
  localparam int HEX64_DIGITS = VALUE_W / 4;
  localparam int HEX32_DIGITS = 32 / 4;
  localparam int REMAIN_W   = $clog2(DEC_DIGITS + 1);
  localparam int BITCNT_W   = $clog2(VALUE_W);

  localparam logic [MODE_W-1:0] MODE_DEC      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HEX32_LO = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HEX32_UP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HEX64_LO = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HEX64_UP = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_MINUS    = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] UPPER_OFFSET  = 8'h37;
  localparam logic [CHAR_W-1:0] LOWER_OFFSET  = 8'h57;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] ext;
    ext = {4'h0, d};
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + ext;
    end else if (upper) begin
      digit_char = UPPER_OFFSET + ext;
    end else begin
      digit_char = LOWER_OFFSET + ext;
    end
  endfunction

endpackage

@@ rtl/core/integer_to_ascii_formatter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats a 64-bit value as ASCII, signed decimal or 32/64-bit hex.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel item_valid/item_stall carries value and mode. Output
//   channel char_valid/char_stall carries one character word per cycle
//   unless stalled, most significant digit first, last set on the final word.
//   Decimal: the magnitude passes through a shared shift-and-add-3 step,
//   one bit per cycle. Leading zero digits are then dropped at one per
//   cycle, then an optional '-' and the digits leave one per cycle when
//   the output is not stalled. Hex: nibbles load directly; leading zeros
//   dropped one per cycle.
//   item_stall is high from acceptance until the last word is registered;
//   one item is worked on at a time.
//   A stalled output word is held; the sequencer waits on it.
//   Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [itaf_pkg::VALUE_W-1:0]  value,
  input  logic [itaf_pkg::MODE_W-1:0]   mode,
  output logic                          char_valid,
  input  logic                          char_stall,
  output logic [itaf_pkg::CHAR_W-1:0]   char_code,
  output logic                          last
);

  itaf_pkg::state_t state, state_next;

  logic [itaf_pkg::VALUE_W-1:0]  mag;
  logic [itaf_pkg::BITCNT_W-1:0] bitcnt;
  logic [itaf_pkg::BCD_W-1:0]    digits;
  logic [itaf_pkg::BCD_W-1:0]    digits_dabbled;
  logic [itaf_pkg::REMAIN_W-1:0] remain;
  logic                          neg;
  logic                          upper;

  logic        accept;
  logic        slot_free;
  logic        top_zero;
  logic        is_hex;
  logic        load_sign;
  logic        load_digit;
  logic [3:0]  top_digit;

  itaf_dabble_step u_step (
    .bcd      (digits),
    .bit_in   (mag[itaf_pkg::VALUE_W-1]),
    .bcd_next (digits_dabbled)
  );

  assign top_digit = digits[itaf_pkg::BCD_W-1 -: 4];
  assign top_zero  = (top_digit == 4'd0);
  assign slot_free = !char_valid || !char_stall;
  assign is_hex    = (mode == itaf_pkg::MODE_HEX32_LO) || (mode == itaf_pkg::MODE_HEX32_UP) ||
                     (mode == itaf_pkg::MODE_HEX64_LO) || (mode == itaf_pkg::MODE_HEX64_UP);

  always_comb begin
    state_next = state;
    case (state)
      itaf_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = is_hex ? itaf_pkg::ST_SKIP : itaf_pkg::ST_CONVERT;
        end
      end
      itaf_pkg::ST_CONVERT: begin
        if (bitcnt == itaf_pkg::BITCNT_W'(itaf_pkg::VALUE_W - 1)) begin
          state_next = itaf_pkg::ST_SKIP;
        end
      end
      itaf_pkg::ST_SKIP: begin
        if (!(top_zero && remain > itaf_pkg::REMAIN_W'(1))) begin
          state_next = neg ? itaf_pkg::ST_SIGN : itaf_pkg::ST_EMIT;
        end
      end
      itaf_pkg::ST_SIGN: begin
        if (slot_free) begin
          state_next = itaf_pkg::ST_EMIT;
        end
      end
      itaf_pkg::ST_EMIT: begin
        if (slot_free && remain == itaf_pkg::REMAIN_W'(1)) begin
          state_next = itaf_pkg::ST_IDLE;
        end
      end
      default: state_next = itaf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    case (state)
      itaf_pkg::ST_IDLE:    item_stall = 1'b0;
      itaf_pkg::ST_SIGN:    load_sign  = slot_free;
      itaf_pkg::ST_EMIT:    load_digit = slot_free;
      default: begin
      end
    endcase
  end

  assign accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= itaf_pkg::ST_IDLE;
      char_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_sign || load_digit) begin
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bitcnt <= '0;
      upper  <= (mode == itaf_pkg::MODE_HEX32_UP) || (mode == itaf_pkg::MODE_HEX64_UP);
      if (is_hex) begin
        neg <= 1'b0;
        mag <= value;
        if (mode == itaf_pkg::MODE_HEX32_LO || mode == itaf_pkg::MODE_HEX32_UP) begin
          digits <= {value[31:0], (itaf_pkg::BCD_W - 32)'(0)};
          remain <= itaf_pkg::REMAIN_W'(itaf_pkg::HEX32_DIGITS);
        end else begin
          digits <= {value, (itaf_pkg::BCD_W - itaf_pkg::VALUE_W)'(0)};
          remain <= itaf_pkg::REMAIN_W'(itaf_pkg::HEX64_DIGITS);
        end
      end else begin
        neg    <= value[itaf_pkg::VALUE_W-1];
        mag    <= value[itaf_pkg::VALUE_W-1] ? (~value + 64'd1) : value;
        digits <= '0;
        remain <= itaf_pkg::REMAIN_W'(itaf_pkg::DEC_DIGITS);
      end
    end else if (state == itaf_pkg::ST_CONVERT) begin
      digits <= digits_dabbled;
      mag    <= {mag[itaf_pkg::VALUE_W-2:0], 1'b0};
      bitcnt <= bitcnt + itaf_pkg::BITCNT_W'(1);
    end else if (state == itaf_pkg::ST_SKIP) begin
      if (top_zero && remain > itaf_pkg::REMAIN_W'(1)) begin
        digits <= {digits[itaf_pkg::BCD_W-5:0], 4'h0};
        remain <= remain - itaf_pkg::REMAIN_W'(1);
      end
    end else if (load_digit) begin
      digits <= {digits[itaf_pkg::BCD_W-5:0], 4'h0};
      remain <= remain - itaf_pkg::REMAIN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_sign) begin
      char_code <= itaf_pkg::CHAR_MINUS;
      last      <= 1'b0;
    end else if (load_digit) begin
      char_code <= itaf_pkg::digit_char(top_digit, upper);
      last      <= (remain == itaf_pkg::REMAIN_W'(1));
    end
  end

endmodule

@@ rtl/core/itaf_dabble_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaf_dabble_step
// One shift-and-add-3 step of binary to BCD conversion over all digits.
// ----------------------------------------------------------------------------
module itaf_dabble_step (
  input  logic [itaf_pkg::BCD_W-1:0] bcd,
  input  logic                       bit_in,
  output logic [itaf_pkg::BCD_W-1:0] bcd_next
);

  logic [itaf_pkg::BCD_W-1:0] adjusted;

  always_comb begin
    for (int i = 0; i < itaf_pkg::DEC_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        adjusted[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        adjusted[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  assign bcd_next = {adjusted[itaf_pkg::BCD_W-2:0], bit_in};

endmodule

@@ rtl/core/itaf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaf_checker
// Port-level checks on the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module itaf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_stall,
  input logic [itaf_pkg::VALUE_W-1:0] value,
  input logic [itaf_pkg::MODE_W-1:0]  mode,
  input logic                         char_valid,
  input logic                         char_stall,
  input logic [itaf_pkg::CHAR_W-1:0]  char_code,
  input logic                         last
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !char_valid && !item_stall)
    else $error("output not empty or input busy after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("new word taken while previous number in progress");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid)
    else $error("stalled character word dropped");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> $stable(char_code) && $stable(last))
    else $error("stalled character word changed");

endmodule

bind integer_to_ascii_formatter_top itaf_checker u_itaf_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Random and directed checks of the integer to ASCII formatter. Numbers go in
// over a bursty valid/stall channel. Every character word that leaves under
// a changing stall pattern is compared with a local decimal/hex formatter.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [itaf_pkg::VALUE_W-1:0] value;
    logic [itaf_pkg::MODE_W-1:0]  mode;
  } number_t;

  typedef struct packed {
    logic [itaf_pkg::CHAR_W-1:0] code;
    logic                        last;
  } char_word_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_style_t;

  localparam logic [itaf_pkg::CHAR_W-1:0] CHAR_LOWER_A = "a";
  localparam logic [itaf_pkg::CHAR_W-1:0] CHAR_UPPER_A = "A";
  localparam int RANDOM_ITEMS = 148;
  localparam int TAIL_CYCLES  = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [itaf_pkg::VALUE_W-1:0] value = '0;
  logic [itaf_pkg::MODE_W-1:0] mode = itaf_pkg::MODE_DEC;
  logic char_valid;
  logic char_stall = 1'b0;
  logic [itaf_pkg::CHAR_W-1:0] char_code;
  logic last;

  number_t    pending_numbers[$];
  char_word_t expected_chars[$];
  number_t    next_number;

  int burst_left = 1;
  int gap_left = 0;
  rx_style_t rx_style = RX_OPEN;
  int rx_span = 0;
  int rx_period = 2;
  int rx_tick = 0;

  int mismatches = 0;
  int chars_checked = 0;
  int dec_numbers = 0;
  int hex_numbers = 0;

  integer_to_ascii_formatter_top DUT (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .value      (value),
    .mode       (mode),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .last       (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the characters of one number, most significant first.
  function automatic void format_number(input logic [itaf_pkg::VALUE_W-1:0] v,
                                        input logic [itaf_pkg::MODE_W-1:0] m);
    logic [itaf_pkg::CHAR_W-1:0] digits[$];
    logic [itaf_pkg::VALUE_W-1:0] mag;
    logic [3:0] nib;
    logic [itaf_pkg::CHAR_W-1:0] letter_base;
    char_word_t w;
    if (m == itaf_pkg::MODE_HEX32_LO || m == itaf_pkg::MODE_HEX32_UP ||
        m == itaf_pkg::MODE_HEX64_LO || m == itaf_pkg::MODE_HEX64_UP) begin
      letter_base = (m == itaf_pkg::MODE_HEX32_UP || m == itaf_pkg::MODE_HEX64_UP) ?
                    CHAR_UPPER_A : CHAR_LOWER_A;
      mag = (m == itaf_pkg::MODE_HEX32_LO || m == itaf_pkg::MODE_HEX32_UP) ?
            {32'h0, v[31:0]} : v;
      do begin
        nib = mag[3:0];
        if (nib < 4'd10) digits.push_back(itaf_pkg::CHAR_ZERO + {4'h0, nib});
        else digits.push_back(letter_base + {4'h0, nib} - 8'd10);
        mag = mag >> 4;
      end while (mag != 0);
      hex_numbers++;
    end else begin
      mag = v[itaf_pkg::VALUE_W-1] ? (~v + 64'd1) : v;
      do begin
        digits.push_back(itaf_pkg::CHAR_ZERO + 8'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 0);
      if (v[itaf_pkg::VALUE_W-1]) digits.push_back(itaf_pkg::CHAR_MINUS);
      dec_numbers++;
    end
    for (int k = digits.size() - 1; k >= 0; k--) begin
      w.code = digits[k];
      w.last = (k == 0);
      expected_chars.push_back(w);
    end
  endfunction

  function automatic void note_mismatch(input string what, input char_word_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("tb: %s at %0t: want code %h last %b, got code %h last %b",
               what, $realtime, want.code, want.last, char_code, last);
  endfunction

  function automatic void queue_number(input logic [itaf_pkg::VALUE_W-1:0] v,
                                       input logic [itaf_pkg::MODE_W-1:0] m);
    number_t n;
    n.value = v;
    n.mode = m;
    pending_numbers.push_back(n);
  endfunction

  function automatic logic [itaf_pkg::VALUE_W-1:0] random_value();
    logic [itaf_pkg::VALUE_W-1:0] r;
    logic [itaf_pkg::VALUE_W-1:0] p;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return r;
      1: return r >> $urandom_range(0, 63);
      2: return ~(r >> $urandom_range(20, 63)) + 64'd1;
      3: begin
        p = 64'd1;
        repeat ($urandom_range(0, 19)) p = p * 64'd10;
        return p - 64'($urandom_range(0, 1));
      end
      default: return {($urandom_range(0, 1) != 0) ? 32'h0 : $urandom, $urandom};
    endcase
  endfunction

  // Sender: bursts of words with random gaps; hold the word while stalled.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) format_number(value, mode);
      if (!(item_valid && item_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (pending_numbers.size() > 0) begin
          next_number = pending_numbers.pop_front();
          value <= next_number.value;
          mode <= next_number.mode;
          item_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted word, then pick the next stall.
  always @(posedge clk) begin
    if (rst) begin
      char_stall <= 1'b0;
    end else begin
      if (char_valid && !char_stall) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          note_mismatch("unexpected word", '0);
        end else begin
          if (expected_chars[0].code !== char_code || expected_chars[0].last !== last)
            note_mismatch("mismatch", expected_chars[0]);
          void'(expected_chars.pop_front());
        end
      end
      if (rx_span == 0) begin
        rx_style = rx_style_t'($urandom_range(0, 2));
        rx_span = $urandom_range(30, 200);
        rx_period = $urandom_range(2, 8);
      end
      rx_span--;
      rx_tick++;
      case (rx_style)
        RX_OPEN:   char_stall <= 1'b0;
        RX_RANDOM: char_stall <= ($urandom_range(0, 2) == 0);
        default:   char_stall <= (rx_tick % rx_period) != 0;
      endcase
    end
  end

  initial begin
    queue_number(64'd0, itaf_pkg::MODE_DEC);
    queue_number(64'd1, itaf_pkg::MODE_DEC);
    queue_number(64'd9, itaf_pkg::MODE_DEC);
    queue_number(64'd10, itaf_pkg::MODE_DEC);
    queue_number(64'hFFFF_FFFF_FFFF_FFFF, itaf_pkg::MODE_DEC);
    queue_number(64'hFFFF_FFFF_FFFF_FFF6, itaf_pkg::MODE_DEC);
    queue_number(64'h7FFF_FFFF_FFFF_FFFF, itaf_pkg::MODE_DEC);
    queue_number(64'h8000_0000_0000_0000, itaf_pkg::MODE_DEC);
    queue_number(64'd1000000000000000000, itaf_pkg::MODE_DEC);
    queue_number(64'd9999999999999999999, itaf_pkg::MODE_DEC);
    queue_number(64'd0, itaf_pkg::MODE_HEX32_LO);
    queue_number(64'hDEAD_BEEF_CAFE_F00D, itaf_pkg::MODE_HEX32_LO);
    queue_number(64'hFFFF_FFFF_FFFF_FFFF, itaf_pkg::MODE_HEX32_UP);
    queue_number(64'h1234_5678_0000_00AB, itaf_pkg::MODE_HEX32_UP);
    queue_number(64'h0000_0000_0000_0010, itaf_pkg::MODE_HEX64_LO);
    queue_number(64'h0123_4567_89AB_CDEF, itaf_pkg::MODE_HEX64_LO);
    queue_number(64'hFEDC_BA98_7654_3210, itaf_pkg::MODE_HEX64_UP);
    queue_number(64'd0, itaf_pkg::MODE_HEX64_UP);
    queue_number(64'hFFFF_FFFF_FFFF_FFFF, itaf_pkg::MODE_HEX64_UP);
    queue_number(64'h8000_0000_0000_0000, 3'd5);
    queue_number(64'd12345, 3'd6);
    queue_number(64'hFFFF_FFFF_FFFF_FF85, 3'd7);
    for (int i = 0; i < RANDOM_ITEMS; i++)
      queue_number(random_value(),
                   ($urandom_range(0, 9) == 0) ?
                   itaf_pkg::MODE_W'($urandom_range(5, 7)) :
                   itaf_pkg::MODE_W'($urandom_range(0, 4)));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending_numbers.size() != 0 || item_valid || expected_chars.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("tb: %0d numbers formatted (%0d decimal, %0d hex), %0d characters checked",
             dec_numbers + hex_numbers, dec_numbers, hex_numbers, chars_checked);
    if (mismatches > 10) $display("tb: %0d mismatches in total", mismatches);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: timeout with %0d characters outstanding", expected_chars.size());
    $display("tb: failure");
    $finish;
  end

endmodule

@@ integer_to_ascii_formatter_top.f @@
rtl/core/itaf_pkg.sv
rtl/core/itaf_dabble_step.sv
rtl/core/integer_to_ascii_formatter_top.sv
rtl/core/itaf_checker.sv
test/tb.sv
